// ----- rtl/core/bdds_pkg.sv -----
// Shared types and constants for the binary to decimal digit scan block.
`timescale 1ns / 1ps
`default_nettype none

package bdds_pkg;

    localparam int VALUE_W     = 32;
    localparam int POS_W       = 3;
    localparam int DIGIT_W     = 4;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    // ceil(2^35 / 10): floor(x * RECIP10 / 2^35) == x / 10 for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    typedef struct packed {
        logic [VALUE_W-1:0] quot;
        logic [DIGIT_W-1:0] digit;
    } div10_t;

endpackage

`default_nettype wire

// ----- rtl/core/bdds_div10.sv -----
// Divide-by-ten unit: quotient by reciprocal multiply, remainder as the low digit.
`timescale 1ns / 1ps
`default_nettype none

module bdds_div10 (
    input  wire logic [bdds_pkg::VALUE_W-1:0] dividend,
    output bdds_pkg::div10_t                  res
);
    import bdds_pkg::*;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   tenq;
    logic [DIGIT_W-1:0]   rem;

    assign prod = (2*VALUE_W)'(dividend) * (2*VALUE_W)'(RECIP10);
    assign quot = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
    // 10*q as (q << 3) + (q << 1)
    assign tenq = {quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0};
    // remainder is below ten, so the low bits of the difference are enough
    assign rem  = dividend[DIGIT_W-1:0] - tenq[DIGIT_W-1:0];

    assign res.quot  = quot;
    assign res.digit = rem;

endmodule

`default_nettype wire

// ----- rtl/core/binary_to_decimal_digit_scan.sv -----
// Top level: splits a 32-bit number into decimal digits, one result per cycle while the receiver accepts them.
//
// Usage:
//   Input channel (in_valid/in_ready, value) takes one unsigned number per request.
//   Output channel (out_valid/out_ready, position, digit, last) gives one result
//   per display digit, least significant digit first; position starts at
//   DIGITS-1 and counts down, last marks the final digit of the number.
//   Up to eight digits are produced; higher digits are dropped silently.
//   The number is registered first; its first digit then enters the output register.
//   Throughput: one digit per cycle while out_ready allows, set by the single
//   divide-by-ten unit that peels one digit per step.
//   The next number is accepted in the same cycle the final digit is loaded
//   into the output register, so back-to-back numbers leave no gap.
//   When the receiver stalls the output register holds its result and the
//   digit walk pauses; in_ready stays low until the final digit enters the
//   output register.
//   Reset clears the busy flag and the output valid; no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_digit_scan #(
    parameter int DIGITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bdds_pkg::VALUE_W-1:0]  value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bdds_pkg::POS_W-1:0]         position,
    output logic [bdds_pkg::DIGIT_W-1:0]       digit,
    output logic                               last
);
    import bdds_pkg::*;

    localparam int NUM = (DIGITS < 1) ? 1 :
                         ((DIGITS > MAX_RESULTS) ? MAX_RESULTS : DIGITS);
    localparam logic [CNT_W-1:0] LAST_K    = CNT_W'(NUM - 1);
    localparam logic [POS_W-1:0] FIRST_POS = POS_W'(DIGITS - 1);

    logic                busy_reg,  busy_next;
    logic [VALUE_W-1:0]  rest_reg,  rest_next;
    logic [CNT_W-1:0]    k_reg,     k_next;
    logic [POS_W-1:0]    pos_reg,   pos_next;
    logic                ovld_reg,  ovld_next;
    logic [POS_W-1:0]    opos_reg,  opos_next;
    logic [DIGIT_W-1:0]  odig_reg,  odig_next;
    logic                olast_reg, olast_next;

    logic   advance;
    logic   at_last;
    logic   take;
    div10_t div;

    bdds_div10 u_div10 (
        .dividend (rest_reg),
        .res      (div)
    );

    assign at_last  = (k_reg == LAST_K);
    assign advance  = busy_reg && (!ovld_reg || out_ready);
    assign in_ready = !busy_reg || (advance && at_last);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        busy_next  = busy_reg;
        rest_next  = rest_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        ovld_next  = ovld_reg;
        opos_next  = opos_reg;
        odig_next  = odig_reg;
        olast_next = olast_reg;

        if (out_ready)
        begin
            ovld_next = 1'b0;
        end

        if (advance)
        begin
            ovld_next  = 1'b1;
            opos_next  = pos_reg;
            odig_next  = div.digit;
            olast_next = at_last;
            rest_next  = div.quot;
            k_next     = k_reg + 1'b1;
            pos_next   = pos_reg - 1'b1;
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end

        // a new request overrides the finished walk in the same cycle
        if (take)
        begin
            busy_next = 1'b1;
            rest_next = value;
            k_next    = '0;
            pos_next  = FIRST_POS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ovld_reg <= 1'b0;
            k_reg    <= '0;
            pos_reg  <= FIRST_POS;
        end
        else
        begin
            busy_reg <= busy_next;
            ovld_reg <= ovld_next;
            k_reg    <= k_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg  <= rest_next;
        opos_reg  <= opos_next;
        odig_reg  <= odig_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ovld_reg;
    assign position  = opos_reg;
    assign digit     = odig_reg;
    assign last      = olast_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bdds_checker.sv -----
// Port-level checker for the digit scan block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bdds_checker #(
    parameter int DIGITS = 8
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [bdds_pkg::POS_W-1:0]    position,
    input wire logic [bdds_pkg::DIGIT_W-1:0]  digit,
    input wire logic                          last
);
    import bdds_pkg::*;

    localparam int NUM = (DIGITS < 1) ? 1 :
                         ((DIGITS > MAX_RESULTS) ? MAX_RESULTS : DIGITS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - NUM);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position) && $stable(digit)
        && $stable(last))
        else $error("stalled result changed");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit <= DIGIT_W'(9))
        else $error("digit above nine");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> position == LAST_POS)
        else $error("final digit at wrong position");

    // a multi-digit number keeps the input closed right after it is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (NUM > 1) && in_valid && in_ready |=> !in_ready)
        else $error("input reopened before digits were produced");

endmodule

bind binary_to_decimal_digit_scan bdds_checker #(.DIGITS(DIGITS)) u_bdds_checker (.*);

`default_nettype wire
